[src/minifloat_to_double_decoder_unit_assert.svh]
// Assertion macros used by the minifloat decoder top level.
// Depends on nothing; included by the decoder top level, which checks its logic.
`ifndef MINIFLOAT_TO_DOUBLE_DECODER_UNIT_ASSERT_SVH
`define MINIFLOAT_TO_DOUBLE_DECODER_UNIT_ASSERT_SVH

// Checks an implication on every clock edge outside reset.
`define MFD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Checks an implication whose consequent holds in the next cycle.
`define MFD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[src/mfd_pkg.sv]
// Package for the minifloat decoder: widths, class codes, register indexes.
// Depends on nothing.
package mfd_pkg;
    localparam int MAX_EXP_BITS  = 11;
    localparam int MAX_MANT_BITS = 52;

    typedef enum logic [2:0] {
        CLS_NORMAL    = 3'd0,
        CLS_SUBNORMAL = 3'd1,
        CLS_ZERO      = 3'd2,
        CLS_INF       = 3'd3,
        CLS_NAN       = 3'd4
    } t_num_class;

    localparam logic REG_EXP_BITS  = 1'b0;
    localparam logic REG_MANT_BITS = 1'b1;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [62:0] INF_BITS  = 63'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [2:0]  num_class;
        logic        sign_bit;
    } t_result;
endpackage

[src/mfd_if.sv]
// Valid/ready channel interfaces for items and configuration writes.
// Depends on nothing.
interface mfd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] pattern;
    modport source (output valid, output pattern, input ready);
    modport sink (input valid, input pattern, output ready);
endinterface

interface mfd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic [2:0]  num_class;
    logic        sign_bit;
    modport source (output valid, output value_bits, output num_class, output sign_bit,
                    input ready);
    modport sink (input valid, input value_bits, input num_class, input sign_bit,
                  output ready);
endinterface

interface mfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/mfd_convert.sv]
// Combinational conversion of one source pattern to binary64.
// Depends on mfd_pkg.
module mfd_convert import mfd_pkg::*; (
    input  logic [63:0] i_pattern,
    input  logic [3:0]  i_exp_w,
    input  logic [5:0]  i_mant_w,
    output t_result     o_result
);
    logic [52:0] frac;
    logic [10:0] emax;
    logic [10:0] efield;
    logic        sign;
    logic [52:0] sig;
    logic [5:0]  top;
    logic signed [13:0] kexp;
    logic signed [13:0] ue;
    logic [52:0] shl_n;
    logic [52:0] shl_s;
    logic [63:0] bits;
    t_num_class  cls;

    // Field extraction at the configured widths.
    always_comb begin
        frac   = i_pattern[52:0] & ((53'd1 << i_mant_w) - 53'd1);
        emax   = 11'((12'd1 << i_exp_w) - 12'd1);
        efield = 11'(i_pattern >> i_mant_w) & emax;
        sign   = i_pattern[6'(i_exp_w) + 6'(i_mant_w)];
    end

    // Significand, exponent, leading one and normalization shifts.
    always_comb begin
        top = '0;
        if (efield == '0) begin
            sig  = frac;
            kexp = 14'sd1 - 14'($signed({3'b0, emax >> 1})) - 14'(i_mant_w);
        end else begin
            sig  = frac | (53'd1 << i_mant_w);
            kexp = 14'($signed({3'b0, efield})) - 14'($signed({3'b0, emax >> 1}))
                   - 14'(i_mant_w);
        end
        for (int p = 0; p < 53; p++) begin
            if (sig[p]) top = 6'(p);
        end
        ue    = kexp + 14'(top);
        shl_n = sig << (6'd52 - top);
        shl_s = sig << 6'(kexp + 14'sd1074);
    end

    // Classification and packing.
    always_comb begin
        if (efield == emax) begin
            if (frac == '0) begin
                cls  = CLS_INF;
                bits = {sign, INF_BITS};
            end else begin
                cls  = CLS_NAN;
                bits = QNAN_BITS;
            end
        end else if (efield == '0 && frac == '0) begin
            cls  = CLS_ZERO;
            bits = {sign, 63'd0};
        end else begin
            cls = (efield == '0) ? CLS_SUBNORMAL : CLS_NORMAL;
            if (ue >= -14'sd1022)
                bits = {sign, 11'(ue + 14'sd1023), shl_n[51:0]};
            else
                bits = {sign, 11'd0, shl_s[51:0]};
        end
        o_result = '{value_bits: bits, num_class: cls, sign_bit: sign};
    end
endmodule

[src/minifloat_to_double_decoder_unit.sv]
// Minifloat to binary64 decoder, top level.
// An accepted input passes through the input register and then the result register.
// Throughput: one item per cycle; both stages advance together unless the output stalls.
// Reset clears the stage valid bits and sets the widths to 8 exponent, 23 fraction.
// Configuration writes are always accepted.
// Depends on mfd_pkg, mfd_if, mfd_convert and the assertion header.
`include "minifloat_to_double_decoder_unit_assert.svh"
module minifloat_to_double_decoder_unit import mfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mfd_in_if.sink   in_ch,
    mfd_out_if.source out_ch,
    mfd_cfg_if.sink  cfg_ch
);
    logic [3:0]  r_exp_bits;
    logic [5:0]  r_mant_bits;
    logic        r_in_vld;
    logic [63:0] r_pattern;
    logic        r_out_vld;
    t_result     r_res;
    t_result     n_res;
    logic [3:0]  exp_w;
    logic [5:0]  mant_w;
    logic        adv;
    logic        out_stall;
    logic        out_nan;
    logic        out_num;

    // Configuration registers.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_bits  <= 4'd8;
            r_mant_bits <= 6'd23;
        end else if (cfg_ch.valid && cfg_ch.index[63:1] == '0) begin
            if (cfg_ch.index[0] == REG_EXP_BITS) r_exp_bits <= cfg_ch.data[3:0];
            else if (cfg_ch.index[0] == REG_MANT_BITS) r_mant_bits <= cfg_ch.data[5:0];
        end
    end

    // Width clamps.
    always_comb begin
        exp_w  = (r_exp_bits == '0) ? 4'd1 :
                 (r_exp_bits > 4'(MAX_EXP_BITS)) ? 4'(MAX_EXP_BITS) : r_exp_bits;
        mant_w = (r_mant_bits == '0) ? 6'd1 :
                 (r_mant_bits > 6'(MAX_MANT_BITS)) ? 6'(MAX_MANT_BITS) : r_mant_bits;
    end

    // Two-stage pipeline; the input stage moves when the result stage can take it.
    assign adv         = !r_out_vld || out_ch.ready;
    assign in_ch.ready = adv || !r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_ch.ready) r_in_vld <= in_ch.valid;
            if (adv) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) r_pattern <= in_ch.pattern;
        if (adv && r_in_vld) r_res <= n_res;
    end

    mfd_convert u_convert (
        .i_pattern (r_pattern),
        .i_exp_w   (exp_w),
        .i_mant_w  (mant_w),
        .o_result  (n_res)
    );

    assign out_ch.valid      = r_out_vld;
    assign out_ch.value_bits = r_res.value_bits;
    assign out_ch.num_class  = r_res.num_class;
    assign out_ch.sign_bit   = r_res.sign_bit;

    // Result conditions watched by the checks below.
    assign out_stall = r_out_vld && !out_ch.ready;
    assign out_nan   = r_out_vld && r_res.num_class == CLS_NAN;
    assign out_num   = r_out_vld && r_res.num_class != CLS_NAN;

    `MFD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_stall, r_out_vld && $stable(r_res))
    `MFD_ASSERT_IMP(a_nan_canon, i_clk, i_rst_n, out_nan, r_res.value_bits == QNAN_BITS)
    `MFD_ASSERT_IMP(a_sign_match, i_clk, i_rst_n, out_num, r_res.value_bits[63] == r_res.sign_bit)
    `MFD_ASSERT_NEXT(a_item_moves, i_clk, i_rst_n, r_in_vld && adv, r_out_vld)
endmodule

[sim/minifloat_to_double_decoder_unit_tb.sv]
// Self-checking testbench for the minifloat to binary64 decoder.
// It sweeps the format widths and checks every result against its own decoder.
// Depends on mfd_pkg, mfd_if and the minifloat_to_double_decoder_unit RTL.
module minifloat_to_double_decoder_unit_tb;
    import mfd_pkg::*;

    localparam logic [63:0] IDX_EXP    = 64'(REG_EXP_BITS);
    localparam logic [63:0] IDX_MANT   = 64'(REG_MANT_BITS);
    localparam logic [63:0] IDX_UNUSED = 64'd2;
    localparam logic [63:0] FRAC_MASK  = 64'h000F_FFFF_FFFF_FFFF;
    localparam int          LATENCY    = 4;

    // Holds the expected decodes in order and compares arriving results.
    class t_decode_scoreboard;
        t_result     pending[$];
        logic [3:0]  exp_reg;
        logic [5:0]  mant_reg;
        int          mismatches;
        int          checked;

        function new();
            exp_reg = 4'd8;
            mant_reg = 6'd23;
            mismatches = 0;
            checked = 0;
        endfunction

        // Builds the binary64 bits of f * 2^k, with f nonzero and below 2^53.
        function logic [63:0] scale_to_double(logic [63:0] f, int k);
            int p;
            int ue;
            p = 0;
            for (int i = 52; i >= 0; i--) begin
                if (f[i]) begin
                    p = i;
                    break;
                end
            end
            ue = k + p;
            if (ue >= -1022) begin
                return (64'(ue + 1023) << 52) | ((f << (52 - p)) & FRAC_MASK);
            end
            return (f << (k + 1074)) & FRAC_MASK;
        endfunction

        function t_result decode(logic [63:0] pat);
            int          ew;
            int          mw;
            int          bias;
            logic [63:0] frac;
            logic [63:0] emax;
            logic [63:0] efield;
            logic        sgn;
            t_result     r;
            ew = (exp_reg < 1) ? 1 : (exp_reg > MAX_EXP_BITS) ? MAX_EXP_BITS : int'(exp_reg);
            mw = (mant_reg < 1) ? 1 :
                 (mant_reg > MAX_MANT_BITS) ? MAX_MANT_BITS : int'(mant_reg);
            frac = pat & ((64'd1 << mw) - 64'd1);
            emax = (64'd1 << ew) - 64'd1;
            efield = (pat >> mw) & emax;
            sgn = pat[ew + mw];
            bias = (1 << (ew - 1)) - 1;
            r.sign_bit = sgn;
            if (efield == emax) begin
                if (frac == 0) begin
                    r.num_class = CLS_INF;
                    r.value_bits = {sgn, INF_BITS};
                end else begin
                    r.num_class = CLS_NAN;
                    r.value_bits = QNAN_BITS;
                end
            end else if (efield == 0) begin
                if (frac == 0) begin
                    r.num_class = CLS_ZERO;
                    r.value_bits = {sgn, 63'd0};
                end else begin
                    r.num_class = CLS_SUBNORMAL;
                    r.value_bits = {sgn, 63'd0} | scale_to_double(frac, 1 - bias - mw);
                end
            end else begin
                r.num_class = CLS_NORMAL;
                r.value_bits = {sgn, 63'd0} |
                    scale_to_double((64'd1 << mw) | frac, int'(efield) - bias - mw);
            end
            return r;
        endfunction

        function void note_pattern(logic [63:0] pat);
            pending.push_back(decode(pat));
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h class %0d sign %0d",
                             got.value_bits, got.num_class, got.sign_bit);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected %h/%0d/%0d, got %h/%0d/%0d",
                             want.value_bits, want.num_class, want.sign_bit,
                             got.value_bits, got.num_class, got.sign_bit);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    mfd_in_if  in_ch();
    mfd_out_if out_ch();
    mfd_cfg_if cfg_ch();

    t_decode_scoreboard sb = new();
    bit idling_on = 1'b1;
    bit hold_request = 1'b0;
    int sent_items = 0;

    minifloat_to_double_decoder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.pattern = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    // Result side: check each accepted item, then pick the next ready value.
    always @(posedge i_clk) begin
        int hold_left;
        if (out_ch.valid && out_ch.ready)
            sb.check_result('{out_ch.value_bits, out_ch.num_class, out_ch.sign_bit});
        if (hold_request && hold_left == 0) begin
            hold_left = 300;
            hold_request <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= i_rst_n && !(idling_on && $urandom_range(99) < 29);
        end
    end

    task automatic send_pattern(logic [63:0] pat);
        while (idling_on && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pattern <= pat;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_pattern(pat);
        sent_items++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // One register write, after which the write channel goes idle.
    task automatic write_reg(logic [63:0] idx, logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == IDX_EXP) sb.exp_reg = value[3:0];
        else if (idx == IDX_MANT) sb.mant_reg = value[5:0];
        @(posedge i_clk);
    endtask

    // Assembles a pattern from fields, with random junk above the sign.
    function automatic logic [63:0] make_pattern(int ew, int mw, logic sgn,
                                                 logic [63:0] ef, logic [63:0] fr);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if (ew + mw < 63) junk = (junk >> (ew + mw + 1)) << (ew + mw + 1);
        else junk = '0;
        return junk | (64'(sgn) << (ew + mw)) | ((ef & ((64'd1 << ew) - 1)) << mw) |
               (fr & ((64'd1 << mw) - 1));
    endfunction

    // Directed corners then random items for one width setting.
    task automatic run_phase(int ew, int mw, int random_count);
        logic [63:0] emax;
        logic [63:0] mmax;
        logic [63:0] ef;
        logic [63:0] fr;
        int          sel;
        emax = (64'd1 << ew) - 1;
        mmax = (64'd1 << mw) - 1;
        for (int s = 0; s < 2; s++) begin
            send_pattern(make_pattern(ew, mw, s[0], 0, 0));
            send_pattern(make_pattern(ew, mw, s[0], emax, 0));
            send_pattern(make_pattern(ew, mw, s[0], emax, mmax));
            send_pattern(make_pattern(ew, mw, s[0], 0, 1));
            send_pattern(make_pattern(ew, mw, s[0], 0, mmax));
            send_pattern(make_pattern(ew, mw, s[0], 1, 0));
            send_pattern(make_pattern(ew, mw, s[0], emax - 1, mmax));
        end
        send_pattern('1);
        send_pattern('0);
        for (int n = 0; n < random_count; n++) begin
            sel = $urandom_range(9);
            ef = (sel < 2) ? 0 : (sel < 4) ? emax : {$urandom, $urandom};
            sel = $urandom_range(9);
            fr = (sel < 2) ? 0 : (sel < 3) ? 1 : {$urandom, $urandom};
            if ($urandom_range(9) == 0) send_pattern({$urandom, $urandom});
            else send_pattern(make_pattern(ew, mw, $urandom_range(1), ef, fr));
        end
        wait_drained();
    endtask

    task automatic set_widths(logic [63:0] e_val, logic [63:0] m_val);
        write_reg(IDX_EXP, e_val);
        write_reg(IDX_MANT, m_val);
    endtask

    function automatic int clamp(int v, int hi);
        return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    initial begin
        int ew_list[10] = '{8, 11, 1, 5, 11, 1, 0, 15, 4, 2};
        int mw_list[10] = '{23, 52, 1, 10, 1, 52, 0, 63, 3, 1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset widths first, then a write to an unknown index that must be ignored.
        run_phase(8, 23, 40);
        write_reg(IDX_UNUSED, 64'h3);
        run_phase(8, 23, 10);
        for (int i = 0; i < 10; i++) begin
            // Upper data bits beyond the register width are junk and ignored.
            set_widths({$urandom, 28'd0, ew_list[i][3:0]}, {$urandom, 26'd0, mw_list[i][5:0]});
            if (i == 3) idling_on = 1'b0;
            if (i == 4) idling_on = 1'b1;
            if (i == 5) hold_request = 1'b1;
            run_phase(clamp(ew_list[i], MAX_EXP_BITS), clamp(mw_list[i], MAX_MANT_BITS), 42);
        end
        repeat (LATENCY) @(posedge i_clk);
        $display("Checked %0d results from %0d items over eleven width settings,",
                 sb.checked, sent_items);
        $display("including clamped widths, specials, stalls and backpressure.");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Timeout waiting for the block");
        $display("Simulation FAILED");
        $finish;
    end
endmodule
